// File: src/chunked_body_decoder_assert.svh
// ----------------------------------------------------------------------------
// chunked body decoder assertion macros
// shared property forms for the decoder checks, clocked on clock,
// quiet while reset is high
// ----------------------------------------------------------------------------
`ifndef CHUNKED_BODY_DECODER_ASSERT_SVH
`define CHUNKED_BODY_DECODER_ASSERT_SVH

// condition in the same cycle
`define CBD_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("chunked body decoder check failed");

// condition in the following cycle
`define CBD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("chunked body decoder check failed");

`endif

// File: src/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg
// types, character codes and helpers shared by the chunked body decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbd_pkg;

   // default width of the chunk size counter
   localparam int SIZE_BITS_DEFAULT = 32;

   // request kinds
   localparam logic KIND_BYTE    = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   // response status codes
   localparam logic [1:0] ST_RUN  = 2'd0;
   localparam logic [1:0] ST_DONE = 2'd1;
   localparam logic [1:0] ST_ERR  = 2'd2;

   // characters of interest
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_F  = 8'h46;

   // decoder phase, one-hot
   typedef enum logic [7:0] {
      PH_SIZE    = 8'b0000_0001,
      PH_SIZE_CR = 8'b0000_0010,
      PH_DATA    = 8'b0000_0100,
      PH_DATA_CR = 8'b0000_1000,
      PH_DATA_LF = 8'b0001_0000,
      PH_TRAILER = 8'b0010_0000,
      PH_DONE    = 8'b0100_0000,
      PH_ERR     = 8'b1000_0000
   } cbd_phase_type;

   // single-bit line tracking flags
   typedef struct packed {
      logic size_bad;
      logic in_extension;
      logic trailer_nonempty;
      logic cr_pending;
   } cbd_flags_type;

   // one response
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       payload_valid;
      logic [1:0] status;
   } cbd_result_type;

   // hex digit decode: bit 4 set when the character is a hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c >= CH_0 && c <= CH_9) begin
         v = c - CH_0;
         return {1'b1, v[3:0]};
      end else if (c >= CH_LO_A && c <= CH_LO_F) begin
         v = c - CH_LO_A + 8'd10;
         return {1'b1, v[3:0]};
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
         v = c - CH_UP_A + 8'd10;
         return {1'b1, v[3:0]};
      end
      return 5'd0;
   endfunction

endpackage

// File: src/cbd_step.sv
// ----------------------------------------------------------------------------
// cbd_step
// next-state and response logic for one request: phase update, size
// nibble shift, data countdown and trailer line scan
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbd_step #(
   parameter int SIZE_BITS = cbd_pkg::SIZE_BITS_DEFAULT
) (
   input  cbd_pkg::cbd_phase_type  phase_i,
   input  logic [SIZE_BITS-1:0]    bytes_left_i,
   input  cbd_pkg::cbd_flags_type  flags_i,
   input  logic                    kind_i,
   input  logic [7:0]              byte_i,
   output cbd_pkg::cbd_phase_type  phase_o,
   output logic [SIZE_BITS-1:0]    bytes_left_o,
   output cbd_pkg::cbd_flags_type  flags_o,
   output cbd_pkg::cbd_result_type result_o
);
   import cbd_pkg::*;

   localparam logic [SIZE_BITS-1:0] ONE = {{(SIZE_BITS-1){1'b0}}, 1'b1};

   logic [4:0]           nib;
   logic [SIZE_BITS-1:0] bytes_dec;
   logic                 size_zero;
   logic                 size_top_busy;
   cbd_phase_type        end_phase;
   logic                 pv;

   // shared helpers
   always_comb begin
      nib           = hex_digit(byte_i);
      bytes_dec     = bytes_left_i - ONE;
      size_zero     = (bytes_left_i == '0);
      size_top_busy = (bytes_left_i[SIZE_BITS-1 -: 4] != 4'd0);
      if (flags_i.size_bad) begin
         end_phase = PH_ERR;
      end else if (size_zero) begin
         end_phase = PH_TRAILER;
      end else begin
         end_phase = PH_DATA;
      end
   end

   // phase machine
   always_comb begin
      phase_o      = phase_i;
      bytes_left_o = bytes_left_i;
      flags_o      = flags_i;
      pv           = 1'b0;
      if (kind_i == KIND_RESTART) begin
         phase_o      = PH_SIZE;
         bytes_left_o = '0;
         flags_o      = '0;
      end else begin
         unique case (phase_i)
            PH_SIZE: begin
               priority if (byte_i == CH_CR) begin
                  phase_o = PH_SIZE_CR;
               end else if (byte_i == CH_LF) begin
                  phase_o              = end_phase;
                  flags_o.size_bad     = 1'b0;
                  flags_o.in_extension = 1'b0;
                  if (end_phase == PH_TRAILER) begin
                     flags_o.trailer_nonempty = 1'b0;
                     flags_o.cr_pending       = 1'b0;
                  end
               end else if (!flags_i.in_extension) begin
                  priority if (byte_i == CH_SEMI) begin
                     flags_o.in_extension = 1'b1;
                  end else if (!nib[4]) begin
                     flags_o.size_bad = 1'b1;
                  end else if (!flags_i.size_bad) begin
                     if (size_top_busy) begin
                        flags_o.size_bad = 1'b1;
                     end else begin
                        bytes_left_o = {bytes_left_i[SIZE_BITS-5:0], nib[3:0]};
                     end
                  end
               end
            end
            PH_SIZE_CR: begin
               if (byte_i == CH_LF) begin
                  phase_o              = end_phase;
                  flags_o.size_bad     = 1'b0;
                  flags_o.in_extension = 1'b0;
                  if (end_phase == PH_TRAILER) begin
                     flags_o.trailer_nonempty = 1'b0;
                     flags_o.cr_pending       = 1'b0;
                  end
               end else begin
                  phase_o = PH_ERR;
               end
            end
            PH_DATA: begin
               pv           = 1'b1;
               bytes_left_o = bytes_dec;
               if (bytes_dec == '0) begin
                  phase_o = PH_DATA_CR;
               end
            end
            PH_DATA_CR: begin
               phase_o = (byte_i == CH_CR) ? PH_DATA_LF : PH_ERR;
            end
            PH_DATA_LF: begin
               phase_o      = (byte_i == CH_LF) ? PH_SIZE : PH_ERR;
               bytes_left_o = '0;
            end
            PH_TRAILER: begin
               flags_o.cr_pending = 1'b0;
               // lf right after a line-ending cr is swallowed
               if (!(flags_i.cr_pending && byte_i == CH_LF)) begin
                  priority if (byte_i == CH_CR || byte_i == CH_LF) begin
                     flags_o.cr_pending       = (byte_i == CH_CR);
                     flags_o.trailer_nonempty = 1'b0;
                     if (!flags_i.trailer_nonempty) begin
                        phase_o = PH_DONE;
                     end
                  end else begin
                     flags_o.trailer_nonempty = 1'b1;
                  end
               end
            end
            default: begin
               // complete and error hold until restart
            end
         endcase
      end
   end

   // response fields
   always_comb begin
      result_o.payload_byte  = pv ? byte_i : 8'd0;
      result_o.payload_valid = pv;
      if (phase_o == PH_DONE) begin
         result_o.status = ST_DONE;
      end else if (phase_o == PH_ERR) begin
         result_o.status = ST_ERR;
      end else begin
         result_o.status = ST_RUN;
      end
   end

endmodule

// File: src/chunked_body_decoder.sv
// The decoder takes one request per clock (a body byte or a restart) unless the
// response side stalls, and answers each with one response: the request is
// registered, its byte runs through the phase and size logic, and the response
// lands in an output register. Sustained rate is one request per cycle without
// stalls, as the phase and chunk-size registers feed back through the step logic.
// A response-side stall holds the output register and, once it holds a request,
// the input register; the block otherwise keeps both stages moving.
// ----------------------------------------------------------------------------
// chunked_body_decoder
// top level: input register, decoder state, step logic and response register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "chunked_body_decoder_assert.svh"

module chunked_body_decoder #(
   parameter int SIZE_BITS = cbd_pkg::SIZE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [7:0] req_byte_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_payload_valid,
   output logic [1:0] rsp_status
);
   import cbd_pkg::*;

   logic                 in_valid_ff;
   logic                 in_kind_ff;
   logic [7:0]           in_byte_ff;
   logic                 out_free;
   logic                 advance;

   cbd_phase_type        phase_ff,      phase_in;
   logic [SIZE_BITS-1:0] bytes_left_ff, bytes_left_in;
   cbd_flags_type        flags_ff,      flags_in;
   cbd_result_type       result_in;
   cbd_result_type       rsp_ff;
   logic                 rsp_valid_ff;

   // handshake control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_kind_ff <= req_kind;
         in_byte_ff <= req_byte_value;
      end
   end

   // per-byte decode
   cbd_step #(
      .SIZE_BITS (SIZE_BITS)
   ) u_step (
      .phase_i      (phase_ff),
      .bytes_left_i (bytes_left_ff),
      .flags_i      (flags_ff),
      .kind_i       (in_kind_ff),
      .byte_i       (in_byte_ff),
      .phase_o      (phase_in),
      .bytes_left_o (bytes_left_in),
      .flags_o      (flags_in),
      .result_o     (result_in)
   );

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SIZE;
         bytes_left_ff <= '0;
         flags_ff      <= '0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         flags_ff      <= flags_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload_byte  = rsp_ff.payload_byte;
   assign rsp_payload_valid = rsp_ff.payload_valid;
   assign rsp_status        = rsp_ff.status;

   // checks
   `CBD_ASSERT_SAME(a_payload_in_progress, rsp_valid_ff && rsp_ff.payload_valid, rsp_ff.status == ST_RUN)
   `CBD_ASSERT_SAME(a_payload_phase, rsp_valid_ff && rsp_ff.payload_valid, phase_ff == PH_DATA || phase_ff == PH_DATA_CR)
   `CBD_ASSERT_NEXT(a_restart_clears, advance && in_kind_ff == KIND_RESTART, phase_ff == PH_SIZE && bytes_left_ff == '0)
   `CBD_ASSERT_NEXT(a_done_sticky, phase_ff == PH_DONE && !(advance && in_kind_ff == KIND_RESTART), phase_ff == PH_DONE)

endmodule

// File: bench/tb_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// tb_chunked_body_decoder
// self-checking bench: a queue of body bytes and restarts drives the decoder
// through bursts and gaps while the response side stalls on its own pattern;
// every accepted request is run through a local decoder model and each
// response is checked field by field against the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_chunked_body_decoder;
   import cbd_pkg::*;

   localparam int SIZE_W       = 32;
   localparam int ITEM_TARGET  = 1700;
   localparam int DRAIN_CYCLES = 12;
   localparam int LIMIT_CYCLES = 400000;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic       kind;
      logic [7:0] value;
   } decoder_req_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_BURSTY
   } stall_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_kind = KIND_BYTE;
   logic [7:0] req_byte_value = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic       rsp_payload_valid;
   logic [1:0] rsp_status;

   chunked_body_decoder #(
      .SIZE_BITS(SIZE_W)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_byte_value   (req_byte_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_payload_valid(rsp_payload_valid),
      .rsp_status       (rsp_status)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // request and response queues
   decoder_req_type pending_reqs[$];
   cbd_result_type  predicted_rsp_q[$];
   logic [7:0]      body_bytes[$];

   // bookkeeping
   int   mismatch_count = 0;
   int   req_count      = 0;
   int   restart_count  = 0;
   int   rsp_count      = 0;
   int   payload_count  = 0;
   int   done_count     = 0;
   int   err_count      = 0;
   int   cycle_count    = 0;
   logic req_taken      = 1'b0;

   // ------------------------------------------------------------------------
   // decoder model state
   // ------------------------------------------------------------------------
   cbd_phase_type     dec_phase;
   logic [SIZE_W-1:0] dec_size;
   logic              dec_size_bad;
   logic              dec_in_ext;
   logic              dec_trl_nonempty;
   logic              dec_cr_pending;

   function automatic void decoder_clear();
      dec_phase        = PH_SIZE;
      dec_size         = '0;
      dec_size_bad     = 1'b0;
      dec_in_ext       = 1'b0;
      dec_trl_nonempty = 1'b0;
      dec_cr_pending   = 1'b0;
   endfunction

   // hex digit value, or -1 for anything else
   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
      if (c >= CH_LO_A && c <= CH_LO_F) return int'(c - CH_LO_A) + 10;
      if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
      return -1;
   endfunction

   // size line done: error, trailer for size zero, else data
   function automatic void close_size_line();
      if (dec_size_bad) begin
         dec_phase = PH_ERR;
      end else if (dec_size == '0) begin
         dec_phase        = PH_TRAILER;
         dec_trl_nonempty = 1'b0;
         dec_cr_pending   = 1'b0;
      end else begin
         dec_phase = PH_DATA;
      end
      dec_size_bad = 1'b0;
      dec_in_ext   = 1'b0;
   endfunction

   // an empty trailer line finishes the body
   function automatic void close_trailer_line();
      if (!dec_trl_nonempty) dec_phase = PH_DONE;
      dec_trl_nonempty = 1'b0;
   endfunction

   // advance the model by one request and form the response
   function automatic cbd_result_type predict_decode(input logic kind, input logic [7:0] c);
      cbd_result_type r;
      logic           pv;
      int             nib;
      pv = 1'b0;
      if (kind == KIND_RESTART) begin
         decoder_clear();
      end else begin
         case (dec_phase)
            PH_SIZE: begin
               if (c == CH_CR) begin
                  dec_phase = PH_SIZE_CR;
               end else if (c == CH_LF) begin
                  close_size_line();
               end else if (!dec_in_ext) begin
                  if (c == CH_SEMI) begin
                     dec_in_ext = 1'b1;
                  end else begin
                     nib = hex_nibble(c);
                     if (nib < 0) begin
                        dec_size_bad = 1'b1;
                     end else if (!dec_size_bad) begin
                        // a digit that would shift out a set bit is an overflow
                        if (dec_size[SIZE_W-1 -: 4] != 4'd0) dec_size_bad = 1'b1;
                        else dec_size = {dec_size[SIZE_W-5:0], 4'(nib)};
                     end
                  end
               end
            end
            PH_SIZE_CR: begin
               if (c == CH_LF) close_size_line();
               else dec_phase = PH_ERR;
            end
            PH_DATA: begin
               pv       = 1'b1;
               dec_size = dec_size - 1'b1;
               if (dec_size == '0) dec_phase = PH_DATA_CR;
            end
            PH_DATA_CR: begin
               dec_phase = (c == CH_CR) ? PH_DATA_LF : PH_ERR;
            end
            PH_DATA_LF: begin
               dec_phase = (c == CH_LF) ? PH_SIZE : PH_ERR;
               dec_size  = '0;
            end
            PH_TRAILER: begin
               // LF right after a line-ending CR belongs to that CR
               if (dec_cr_pending && c == CH_LF) begin
                  dec_cr_pending = 1'b0;
               end else begin
                  dec_cr_pending = 1'b0;
                  if (c == CH_CR) begin
                     dec_cr_pending = 1'b1;
                     close_trailer_line();
                  end else if (c == CH_LF) begin
                     close_trailer_line();
                  end else begin
                     dec_trl_nonempty = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      r.payload_byte  = pv ? c : 8'h00;
      r.payload_valid = pv;
      r.status        = (dec_phase == PH_DONE) ? ST_DONE :
                        (dec_phase == PH_ERR) ? ST_ERR : ST_RUN;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus building
   // ------------------------------------------------------------------------
   task automatic push_req(input logic kind, input logic [7:0] value);
      decoder_req_type r;
      r.kind  = kind;
      r.value = value;
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_req(KIND_BYTE, s[i]);
   endtask

   // append one byte to the body under construction
   task automatic add_byte(input logic [7:0] b);
      body_bytes.insert(body_bytes.size(), b);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return CH_0 + 8'(v);
      return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(v) - 8'd10;
   endfunction

   // any byte but CR and LF
   function automatic logic [7:0] text_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
      return c;
   endfunction

   task automatic add_line_end();
      if ($urandom_range(0, 2) == 0) begin
         add_byte(CH_LF);
      end else begin
         add_byte(CH_CR);
         add_byte(CH_LF);
      end
   endtask

   // trailer lines may also end on a bare CR
   task automatic add_trailer_end();
      case ($urandom_range(0, 2))
         0: begin
            add_byte(CH_CR);
            add_byte(CH_LF);
         end
         1: add_byte(CH_LF);
         default: add_byte(CH_CR);
      endcase
   endtask

   // hex size with optional leading zeros and extension
   task automatic add_size_line(input logic [63:0] sz);
      int ndig;
      ndig = 1;
      while (ndig < 16 && (sz >> (4 * ndig)) != 64'd0) ndig++;
      if (sz == 64'd0 && $urandom_range(0, 5) == 0) ndig = 0;
      else if ($urandom_range(0, 3) == 0) ndig += $urandom_range(1, 3);
      for (int i = ndig - 1; i >= 0; i--) add_byte(hex_char(4'(sz >> (4 * i))));
      if ($urandom_range(0, 3) == 0) begin
         add_byte(CH_SEMI);
         repeat ($urandom_range(0, 6)) add_byte(text_char());
      end
      add_line_end();
   endtask

   task automatic add_chunk(input int unsigned sz);
      add_size_line(64'(sz));
      repeat (sz) add_byte(8'($urandom_range(0, 255)));
      add_byte(CH_CR);
      add_byte(CH_LF);
   endtask

   // one body: mostly well formed with random content, some damaged or noise
   task automatic build_body();
      int roll;
      int pos;
      roll = $urandom_range(0, 99);
      body_bytes.delete();
      if (roll < 5) begin
         // size that cannot fit the counter
         add_size_line(({32'($urandom), 32'($urandom)} >> $urandom_range(0, 28))
                       | 64'h1_0000_0000);
         repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
      end else if (roll < 8) begin
         // widest size that still fits, abandoned partway through the data
         add_size_line(($urandom_range(0, 3) == 0) ? 64'hFFFF_FFFF :
                       {32'h0, 32'($urandom) | 32'h1000_0000});
         repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(0, 255)));
      end else if (roll < 12) begin
         repeat ($urandom_range(1, 30)) add_byte(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 3)) begin
            add_chunk(($urandom_range(0, 19) == 0) ? $urandom_range(64, 300) :
                      $urandom_range(1, 16));
         end
         add_size_line(64'd0);
         repeat ($urandom_range(0, 2)) begin
            repeat ($urandom_range(1, 8)) add_byte(text_char());
            add_trailer_end();
         end
         add_trailer_end();
         // bytes after the end of the body
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(0, 255)));
         // damage: one corrupted byte or a cut body
         roll = $urandom_range(0, 99);
         if (roll < 12) begin
            pos = $urandom_range(0, body_bytes.size() - 1);
            body_bytes[pos] = 8'($urandom_range(0, 255));
         end else if (roll < 20) begin
            pos = $urandom_range(1, body_bytes.size());
            while (body_bytes.size() > pos) body_bytes.delete(body_bytes.size() - 1);
         end
      end
      push_req(KIND_RESTART, 8'($urandom_range(0, 255)));
      foreach (body_bytes[i]) push_req(KIND_BYTE, body_bytes[i]);
   endtask

   task automatic log_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
   endtask

   // ------------------------------------------------------------------------
   // request driver: bursts of random length with random gaps
   // ------------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(negedge clock) begin : drive_req
      decoder_req_type nxt;
      if (!reset && !(req_valid && !req_taken)) begin
         req_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            nxt = pending_reqs.pop_front();
            req_valid      <= 1'b1;
            req_kind       <= nxt.kind;
            req_byte_value <= nxt.value;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                            $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // response stall pattern: modes of random length
   // ------------------------------------------------------------------------
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left  = 0;
   int             stall_left = 0;

   always @(negedge clock) begin : drive_stall
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 2));
         mode_left  = $urandom_range(40, 300);
      end else begin
         mode_left--;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: begin
               if ($urandom_range(0, 5) == 0) begin
                  stall_left = $urandom_range(0, 11);
                  rsp_stall <= 1'b1;
               end else begin
                  rsp_stall <= 1'b0;
               end
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // monitor: check responses, then predict newly accepted requests
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      cbd_result_type got;
      cbd_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_payload_byte, rsp_payload_valid, rsp_status};
            rsp_count++;
            if (got.payload_valid === 1'b1) payload_count++;
            if (got.status === ST_DONE) done_count++;
            if (got.status === ST_ERR) err_count++;
            if (predicted_rsp_q.size() == 0) begin
               log_mismatch($sformatf("response %0d with nothing pending: byte %02h valid %0d status %0d",
                                      rsp_count, got.payload_byte, got.payload_valid, got.status));
            end else begin
               want = predicted_rsp_q.pop_front();
               if (got.payload_byte !== want.payload_byte
                   || got.payload_valid !== want.payload_valid
                   || got.status !== want.status)
                  log_mismatch($sformatf({"response %0d: expected byte %02h valid %0d status %0d,",
                                          " got byte %02h valid %0d status %0d"},
                                         rsp_count, want.payload_byte, want.payload_valid,
                                         want.status, got.payload_byte, got.payload_valid,
                                         got.status));
            end
         end
         if (req_valid && !req_stall) begin
            predicted_rsp_q.insert(predicted_rsp_q.size(),
                                   predict_decode(req_kind, req_byte_value));
            req_taken = 1'b1;
            req_count++;
            if (req_kind == KIND_RESTART) restart_count++;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("run stopped at cycle %0d with %0d requests queued, %0d responses pending",
                  cycle_count, pending_reqs.size(), predicted_rsp_q.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin : run_test
      int directed_len;
      decoder_clear();

      // one-byte chunk with extension and bare LF, top byte value as payload
      push_text("1;x");
      push_req(KIND_BYTE, CH_LF);
      push_req(KIND_BYTE, 8'hFF);
      push_req(KIND_BYTE, CH_CR);
      push_req(KIND_BYTE, CH_LF);
      // last chunk, trailer line ended by CR LF (LF swallowed), then empty line
      push_text("0");
      push_req(KIND_BYTE, CH_CR);
      push_req(KIND_BYTE, CH_LF);
      push_text("t");
      push_req(KIND_BYTE, CH_CR);
      push_req(KIND_BYTE, CH_LF);
      push_req(KIND_BYTE, CH_LF);
      // ignored once complete
      push_req(KIND_BYTE, 8'h00);
      // non-hex digit in the size
      push_req(KIND_RESTART, 8'hFF);
      push_text("g");
      push_req(KIND_BYTE, CH_LF);
      // CR on the size line not followed by LF
      push_req(KIND_RESTART, 8'h00);
      push_req(KIND_BYTE, CH_CR);
      push_text("x");
      // empty size line reads as zero, then an empty trailer line
      push_req(KIND_RESTART, 8'h5A);
      push_req(KIND_BYTE, CH_LF);
      push_req(KIND_BYTE, CH_CR);
      // wrong byte after chunk data
      push_req(KIND_RESTART, 8'hA5);
      push_text("1");
      push_req(KIND_BYTE, CH_LF);
      push_req(KIND_BYTE, 8'h00);
      push_text("x");
      directed_len = pending_reqs.size();

      while (pending_reqs.size() < directed_len + ITEM_TARGET) build_body();

      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      wait (pending_reqs.size() == 0 && !req_valid);
      wait (predicted_rsp_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (predicted_rsp_q.size() != 0)
         log_mismatch($sformatf("%0d responses never arrived", predicted_rsp_q.size()));

      $display("checked %0d responses to %0d requests across %0d restarts",
               rsp_count, req_count, restart_count);
      $display("payload bytes %0d, complete-status responses %0d, error-status responses %0d",
               payload_count, done_count, err_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatches in total", mismatch_count);
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/cbd_pkg.sv
src/cbd_step.sv
src/chunked_body_decoder.sv
bench/tb_chunked_body_decoder.sv
